// ===== sv/stts_pkg.sv =====
// shared types and constants of the timer slot table scheduler
`timescale 1ns / 1ps

package stts_pkg;

   // period value of a stopped wake-up clock
   localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

   // result kinds
   localparam logic KIND_FIRED  = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // command codes
   typedef enum logic [1:0] {
      CMD_TICK    = 2'd0,
      CMD_START   = 2'd1,
      CMD_STOP    = 2'd2,
      CMD_TIMEOUT = 2'd3
   } cmd_type;

   // verdict of the slot evaluation unit on one slot
   typedef struct packed {
      logic        fired;
      logic        better;
      logic [31:0] cand;
   } eval_type;

endpackage

// ===== sv/stts_ram.sv =====
// generic single write, single registered read port memory
`timescale 1ns / 1ps

module stts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/stts_eval.sv =====
// shared slot evaluation unit: deadline sum, expiry compare and delay minimum
`timescale 1ns / 1ps

module stts_eval (
   input  logic               clock,
   input  logic               load,
   input  logic [31:0]        update_time,
   input  logic [31:0]        timeout,
   input  logic [31:0]        now,
   input  logic [31:0]        min_delay,
   output stts_pkg::eval_type verdict
);

   logic [32:0] deadline_ff;
   logic [32:0] deadline_in;
   logic [31:0] timeout_ff;
   logic [31:0] timeout_in;
   logic [32:0] remaining;
   logic [32:0] cand;
   logic        fired;

   // first step: 33-bit deadline sum
   always_comb begin
      deadline_in = deadline_ff;
      timeout_in  = timeout_ff;
      if (load) begin
         deadline_in = {1'b0, update_time} + {1'b0, timeout};
         timeout_in  = timeout;
      end
   end

   always_ff @(posedge clock) begin
      deadline_ff <= deadline_in;
      timeout_ff  <= timeout_in;
   end

   // second step: expiry test and candidate delay against the running minimum
   always_comb begin
      fired     = deadline_ff <= {1'b0, now};
      remaining = deadline_ff - {1'b0, now};
      // a restamped slot waits its whole timeout
      cand      = fired ? {1'b0, timeout_ff} : remaining;
      verdict.fired  = fired;
      verdict.better = cand < {1'b0, min_delay};
      verdict.cand   = cand[31:0];
   end

endmodule

// ===== sv/software_timer_table_scheduler.sv =====
// top level of the timer slot table scheduler with its command sequencer
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+-----------------------------
//  request | req_command req_slot req_timeout_value  | taken when start & !busy
//          | req_auto_reload req_now                 |
//  result  | rsp_kind rsp_fired_slot rsp_next_period | one cycle under rsp_valid
//          | rsp_clock_running rsp_period_changed    |
//          | rsp_last                                |
//  config  | csr_wr_en csr_wr_data                   | written when csr_wr_en
//
// start, stop, set timeout and a tick with callbacks disabled pass through S_EXEC,
// which registers the status item. An enabled tick steps each slot through S_ADD
// and S_EVAL, using the shared evaluation unit and the memory read port, then
// sets the clock in S_FINISH, and in S_EMIT sends the fired items in slot order,
// then the status item.
// Reset is synchronous and clears the slot flags, clock state and register.
// The receiver cannot stall; each result item is shown for exactly one cycle.
`timescale 1ns / 1ps

module software_timer_table_scheduler #(
   parameter int SLOT_COUNT = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_command,
   input  logic [2:0]  req_slot,
   input  logic [31:0] req_timeout_value,
   input  logic        req_auto_reload,
   input  logic [31:0] req_now,
   output logic        rsp_valid,
   output logic        rsp_kind,
   output logic [2:0]  rsp_fired_slot,
   output logic [31:0] rsp_next_period,
   output logic        rsp_clock_running,
   output logic        rsp_period_changed,
   output logic        rsp_last,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   localparam int IDX_W = SLOT_COUNT > 1 ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W = $clog2(SLOT_COUNT + 1);
   localparam logic [7:0] SLOT_LIMIT = 8'(SLOT_COUNT);
   localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(SLOT_COUNT);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SLOT_COUNT - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_ADD,
      S_EVAL,
      S_FINISH,
      S_EMIT
   } state_type;

   // sequencer and control registers
   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   disabled_ff, disabled_in;
   logic [SLOT_COUNT-1:0]  present_ff, present_in;
   logic [SLOT_COUNT-1:0]  pending_ff, pending_in;
   logic [SLOT_COUNT-1:0]  auto_ff, auto_in;
   logic [SLOT_COUNT-1:0]  to_valid_ff, to_valid_in;
   logic [SLOT_COUNT-1:0]  fired_mask_ff, fired_mask_in;
   logic [31:0]            period_ff, period_in;
   logic                   clock_on_ff, clock_on_in;
   logic [31:0]            min_ff, min_in;
   logic                   any_ff, any_in;
   logic                   changed_ff, changed_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_kind_ff, rsp_kind_in;
   logic [2:0]             rsp_slot_ff, rsp_slot_in;
   logic                   rsp_changed_ff, rsp_changed_in;
   logic                   rsp_last_ff, rsp_last_in;

   // latched request
   stts_pkg::cmd_type      cmd_ff, cmd_in;
   logic [2:0]             slot_ff, slot_in;
   logic [31:0]            tv_ff, tv_in;
   logic                   ar_ff, ar_in;
   logic [31:0]            now_ff, now_in;

   // datapath signals
   logic [IDX_W-1:0]       rd_addr;
   logic [IDX_W-1:0]       cnt_idx;
   logic [IDX_W-1:0]       slot_idx;
   logic [IDX_W-1:0]       req_idx;
   logic [IDX_W-1:0]       to_idx;
   logic                   slot_ok;
   logic                   req_ok;
   logic [31:0]            rd_ut;
   logic [31:0]            rd_to;
   logic [31:0]            to_eff;
   logic                   ut_we;
   logic [IDX_W-1:0]       ut_waddr;
   logic                   to_we;
   logic                   eval_load;
   stts_pkg::eval_type     verdict;
   logic [31:0]            period_eff;
   logic [31:0]            req_period;
   logic                   prog_en;

   assign cnt_idx  = cnt_ff[IDX_W-1:0];
   assign slot_idx = IDX_W'(slot_ff);
   assign req_idx  = IDX_W'(req_slot);
   assign slot_ok  = {5'b0, slot_ff} < SLOT_LIMIT;
   assign req_ok   = {5'b0, req_slot} < SLOT_LIMIT;

   // timeout entries never written read as one
   assign to_idx = (state_ff == S_EXEC) ? slot_idx : cnt_idx;
   assign to_eff = to_valid_ff[to_idx] ? rd_to : 32'd1;

   // slot memories: update times and timeouts
   stts_ram #(.WIDTH(32), .DEPTH(SLOT_COUNT)) u_ut_ram (
      .clock   (clock),
      .wr_en   (ut_we),
      .wr_addr (ut_waddr),
      .wr_data (now_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_ut)
   );

   stts_ram #(.WIDTH(32), .DEPTH(SLOT_COUNT)) u_to_ram (
      .clock   (clock),
      .wr_en   (to_we),
      .wr_addr (slot_idx),
      .wr_data (tv_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_to)
   );

   stts_eval u_eval (
      .clock       (clock),
      .load        (eval_load),
      .update_time (rd_ut),
      .timeout     (to_eff),
      .now         (now_ff),
      .min_delay   (min_ff),
      .verdict     (verdict)
   );

   // sequencer next state
   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      disabled_in    = csr_wr_en ? csr_wr_data : disabled_ff;
      present_in     = present_ff;
      pending_in     = pending_ff;
      auto_in        = auto_ff;
      to_valid_in    = to_valid_ff;
      fired_mask_in  = fired_mask_ff;
      period_in      = period_ff;
      clock_on_in    = clock_on_ff;
      min_in         = min_ff;
      any_in         = any_ff;
      changed_in     = changed_ff;
      rsp_valid_in   = 1'b0;
      rsp_kind_in    = rsp_kind_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_changed_in = rsp_changed_ff;
      rsp_last_in    = rsp_last_ff;
      cmd_in         = cmd_ff;
      slot_in        = slot_ff;
      tv_in          = tv_ff;
      ar_in          = ar_ff;
      now_in         = now_ff;
      rd_addr        = '0;
      ut_we          = 1'b0;
      ut_waddr       = slot_idx;
      to_we          = 1'b0;
      eval_load      = 1'b0;
      period_eff     = period_ff;
      req_period     = 32'd1;
      prog_en        = 1'b0;

      case (state_ff)
         S_IDLE: begin
            // read the addressed slot, or slot zero for a tick or an out-of-range slot
            if (req_command != stts_pkg::CMD_TICK && req_ok) begin
               rd_addr = req_idx;
            end
            if (start) begin
               cmd_in = stts_pkg::cmd_type'(req_command);
               slot_in = req_slot;
               tv_in = req_timeout_value;
               ar_in = req_auto_reload;
               now_in = req_now;
               cnt_in = '0;
               min_in = stts_pkg::ALL_ONES;
               any_in = 1'b0;
               fired_mask_in = '0;
               if (req_command == stts_pkg::CMD_TICK && !disabled_ff) begin
                  state_in = S_ADD;
               end else begin
                  state_in = S_EXEC;
               end
            end
         end

         S_EXEC: begin
            changed_in = 1'b0;
            if (cmd_ff != stts_pkg::CMD_TICK && slot_ok) begin
               case (cmd_ff)
                  stts_pkg::CMD_START: begin
                     auto_in[slot_idx] = ar_ff;
                     pending_in[slot_idx] = 1'b0;
                     ut_we = 1'b1;
                     if (!present_ff[slot_idx]) begin
                        // first slot of an empty table starts from a stopped period
                        if (present_ff == '0) begin
                           period_eff = stts_pkg::ALL_ONES;
                        end
                        period_in = period_eff;
                        present_in[slot_idx] = 1'b1;
                        prog_en = to_eff < period_eff;
                        req_period = (to_eff == 32'd0) ? 32'd1 : to_eff;
                     end
                  end
                  stts_pkg::CMD_STOP: begin
                     if (present_ff[slot_idx]) begin
                        pending_in[slot_idx] = 1'b1;
                     end
                  end
                  stts_pkg::CMD_TIMEOUT: begin
                     to_we = 1'b1;
                     to_valid_in[slot_idx] = 1'b1;
                     prog_en = present_ff[slot_idx] && !pending_ff[slot_idx] &&
                               (tv_ff < period_ff);
                     req_period = (tv_ff == 32'd0) ? 32'd1 : tv_ff;
                  end
                  default: begin
                  end
               endcase
               // reprogram the clock when the period really moves
               if (prog_en && req_period != period_eff) begin
                  period_in   = req_period;
                  clock_on_in = 1'b1;
                  changed_in  = 1'b1;
               end
            end
            rsp_valid_in   = 1'b1;
            rsp_kind_in    = stts_pkg::KIND_STATUS;
            rsp_slot_in    = 3'd0;
            rsp_changed_in = changed_in;
            rsp_last_in    = 1'b1;
            state_in       = S_IDLE;
         end

         S_ADD: begin
            // deadline sum of the slot just read
            eval_load = 1'b1;
         end

         S_EVAL: begin
            if (cnt_ff != CNT_LAST) begin
               rd_addr = IDX_W'(cnt_ff + 1'b1);
            end
            if (present_ff[cnt_idx]) begin
               if (pending_ff[cnt_idx]) begin
                  // stopped earlier: free it
                  present_in[cnt_idx] = 1'b0;
                  pending_in[cnt_idx] = 1'b0;
               end else if (verdict.fired) begin
                  fired_mask_in[cnt_idx] = 1'b1;
                  ut_we = 1'b1;
                  ut_waddr = cnt_idx;
                  if (!auto_ff[cnt_idx]) begin
                     // one-shot retires in the same tick
                     present_in[cnt_idx] = 1'b0;
                  end else begin
                     any_in = 1'b1;
                     if (verdict.better) begin
                        min_in = verdict.cand;
                     end
                  end
               end else begin
                  any_in = 1'b1;
                  if (verdict.better) begin
                     min_in = verdict.cand;
                  end
               end
            end
            cnt_in = cnt_ff + 1'b1;
         end

         S_FINISH: begin
            if (!any_ff) begin
               // empty table stops the clock
               changed_in  = clock_on_ff || (period_ff != stts_pkg::ALL_ONES);
               clock_on_in = 1'b0;
               period_in   = stts_pkg::ALL_ONES;
            end else begin
               req_period = (min_ff == 32'd0) ? 32'd1 : min_ff;
               changed_in = req_period != period_ff;
               if (req_period != period_ff) begin
                  period_in   = req_period;
                  clock_on_in = 1'b1;
               end
            end
            cnt_in   = '0;
            state_in = S_EMIT;
         end

         S_EMIT: begin
            if (cnt_ff == CNT_END) begin
               rsp_valid_in   = 1'b1;
               rsp_kind_in    = stts_pkg::KIND_STATUS;
               rsp_slot_in    = 3'd0;
               rsp_changed_in = changed_ff;
               rsp_last_in    = 1'b1;
               state_in       = S_IDLE;
            end else begin
               // fired items in slot order
               rsp_valid_in   = fired_mask_ff[cnt_idx];
               rsp_kind_in    = stts_pkg::KIND_FIRED;
               rsp_slot_in    = 3'(cnt_idx);
               rsp_changed_in = 1'b0;
               rsp_last_in    = 1'b0;
               cnt_in         = cnt_ff + 1'b1;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // loop between the two evaluation steps
      if (state_ff == S_ADD) begin
         state_in = S_EVAL;
      end else if (state_ff == S_EVAL) begin
         state_in = (cnt_ff == CNT_LAST) ? S_FINISH : S_ADD;
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         disabled_ff  <= 1'b0;
         present_ff   <= '0;
         pending_ff   <= '0;
         auto_ff      <= '0;
         to_valid_ff  <= '0;
         period_ff    <= stts_pkg::ALL_ONES;
         clock_on_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         disabled_ff  <= disabled_in;
         present_ff   <= present_in;
         pending_ff   <= pending_in;
         auto_ff      <= auto_in;
         to_valid_ff  <= to_valid_in;
         period_ff    <= period_in;
         clock_on_ff  <= clock_on_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      fired_mask_ff  <= fired_mask_in;
      min_ff         <= min_in;
      any_ff         <= any_in;
      changed_ff     <= changed_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_changed_ff <= rsp_changed_in;
      rsp_last_ff    <= rsp_last_in;
      cmd_ff         <= cmd_in;
      slot_ff        <= slot_in;
      tv_ff          <= tv_in;
      ar_ff          <= ar_in;
      now_ff         <= now_in;
   end

   // ports
   assign busy               = state_ff != S_IDLE;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_fired_slot     = rsp_slot_ff;
   assign rsp_next_period    = period_ff;
   assign rsp_clock_running  = clock_on_ff;
   assign rsp_period_changed = rsp_changed_ff;
   assign rsp_last           = rsp_last_ff;

   // a fired item is only ever sent while a tick is still in progress
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !busy) |-> rsp_last)
      else $error("result outside a tick is not the final item");

   // a stopped clock always carries the all-ones period
   assert property (@(posedge clock) disable iff (reset)
      !clock_on_ff |-> (period_ff == stts_pkg::ALL_ONES))
      else $error("clock stopped with a programmed period");

   // the programmed period is never zero
   assert property (@(posedge clock) disable iff (reset)
      period_ff != 32'd0)
      else $error("zero clock period");

   // the final item of one request is never followed at once by another result
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |=> !rsp_valid)
      else $error("result directly after a final item");

endmodule

// ===== tb/software_timer_table_scheduler_test.sv =====
// self-checking testbench of the timer slot table scheduler
`timescale 1ns / 1ps

module software_timer_table_scheduler_test;

   localparam int SLOTS = 8;
   localparam int CYCLE_LIMIT = 200000;
   // settle time after draining, sized from the slot count
   localparam int SETTLE_CYCLES = 3 * SLOTS + 12;

   typedef struct {
      stts_pkg::cmd_type command;
      logic [2:0]        slot;
      logic [31:0]       timeout_value;
      logic              auto_reload;
      logic [31:0]       now;
   } timer_cmd_type;

   typedef struct {
      logic        kind;
      logic [2:0]  fired_slot;
      logic [31:0] next_period;
      logic        clock_running;
      logic        period_changed;
      logic        last;
   } timer_record_type;

   typedef struct {
      bit            csr_row;
      logic          csr_value;
      timer_cmd_type item;
      bit            typed;
      logic [31:0]   period;
      logic          running;
      logic          changed;
   } plan_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_command = stts_pkg::CMD_TICK;
   logic [2:0]  req_slot = 3'd0;
   logic [31:0] req_timeout_value = 32'd0;
   logic        req_auto_reload = 1'b0;
   logic [31:0] req_now = 32'd0;
   logic        rsp_valid;
   logic        rsp_kind;
   logic [2:0]  rsp_fired_slot;
   logic [31:0] rsp_next_period;
   logic        rsp_clock_running;
   logic        rsp_period_changed;
   logic        rsp_last;
   logic        csr_wr_en = 1'b0;
   logic        csr_wr_data = 1'b0;

   // shadow copy of the slot table and wake-up clock
   logic        tbl_present [SLOTS];
   logic        tbl_pending [SLOTS];
   logic        tbl_auto [SLOTS];
   logic [31:0] tbl_timeout [SLOTS];
   logic [31:0] tbl_stamp [SLOTS];
   logic [31:0] wake_period;
   logic        wake_on;
   logic        cb_off;

   timer_record_type owed_records [$];
   plan_row_type     plan [$];
   int               mismatches = 0;
   int               cycle_count = 0;
   bit               calm = 1'b0;
   logic [31:0]      sim_ms = 32'd0;

   software_timer_table_scheduler #(
      .SLOT_COUNT(SLOTS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_command(req_command),
      .req_slot(req_slot),
      .req_timeout_value(req_timeout_value),
      .req_auto_reload(req_auto_reload),
      .req_now(req_now),
      .rsp_valid(rsp_valid),
      .rsp_kind(rsp_kind),
      .rsp_fired_slot(rsp_fired_slot),
      .rsp_next_period(rsp_next_period),
      .rsp_clock_running(rsp_clock_running),
      .rsp_period_changed(rsp_period_changed),
      .rsp_last(rsp_last),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // run-away guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t ns: cycle limit reached", $time);
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic void clear_table();
      for (int i = 0; i < SLOTS; i++) begin
         tbl_present[i] = 1'b0;
         tbl_pending[i] = 1'b0;
         tbl_auto[i] = 1'b0;
         tbl_timeout[i] = 32'd1;
         tbl_stamp[i] = 32'd0;
      end
      wake_period = stts_pkg::ALL_ONES;
      wake_on = 1'b0;
      cb_off = 1'b0;
   endfunction

   // reprogram the wake-up clock, zero rounds up to one
   function automatic logic set_wake_period(input logic [31:0] req);
      logic [31:0] p;
      p = (req == 32'd0) ? 32'd1 : req;
      if (p == wake_period)
         return 1'b0;
      wake_period = p;
      wake_on = 1'b1;
      return 1'b1;
   endfunction

   // apply one item to the shadow table and queue the records it owes
   task automatic timer_table_step(input timer_cmd_type it);
      logic [32:0]      dl;
      logic [32:0]      least;
      logic [32:0]      now33;
      logic             changed;
      logic             anyone;
      logic             empty;
      int               s;
      int               fired [$];
      timer_record_type rec;
      changed = 1'b0;
      s = it.slot;
      now33 = {1'b0, it.now};
      case (it.command)
         stts_pkg::CMD_TICK: begin
            if (!cb_off) begin
               least = {1'b0, stts_pkg::ALL_ONES};
               anyone = 1'b0;
               // fire every expired live slot in slot order
               for (int i = 0; i < SLOTS; i++) begin
                  if (tbl_present[i] && !tbl_pending[i]) begin
                     dl = {1'b0, tbl_stamp[i]} + {1'b0, tbl_timeout[i]};
                     if (dl <= now33) begin
                        tbl_stamp[i] = it.now;
                        if (!tbl_auto[i])
                           tbl_pending[i] = 1'b1;
                        fired.push_back(i);
                     end
                  end
               end
               // free pending slots and look for the nearest deadline
               for (int i = 0; i < SLOTS; i++) begin
                  if (tbl_present[i] && tbl_pending[i]) begin
                     tbl_present[i] = 1'b0;
                     tbl_pending[i] = 1'b0;
                  end else if (tbl_present[i]) begin
                     anyone = 1'b1;
                     dl = {1'b0, tbl_stamp[i]} + {1'b0, tbl_timeout[i]};
                     if (tbl_stamp[i] == it.now) begin
                        if ({1'b0, tbl_timeout[i]} < least)
                           least = {1'b0, tbl_timeout[i]};
                     end else if (dl < now33) begin
                        least = 33'd1;
                     end else if (dl - now33 < least) begin
                        least = dl - now33;
                     end
                  end
               end
               if (!anyone) begin
                  changed = wake_on || (wake_period != stts_pkg::ALL_ONES);
                  wake_on = 1'b0;
                  wake_period = stts_pkg::ALL_ONES;
               end else begin
                  changed = set_wake_period(least[31:0]);
               end
            end
         end
         stts_pkg::CMD_START: begin
            tbl_auto[s] = it.auto_reload;
            if (!tbl_present[s]) begin
               empty = 1'b1;
               for (int i = 0; i < SLOTS; i++)
                  if (tbl_present[i])
                     empty = 1'b0;
               if (empty)
                  wake_period = stts_pkg::ALL_ONES;
               tbl_present[s] = 1'b1;
               tbl_pending[s] = 1'b0;
               tbl_stamp[s] = it.now;
               if (tbl_timeout[s] < wake_period)
                  changed = set_wake_period(tbl_timeout[s]);
            end else begin
               tbl_stamp[s] = it.now;
               tbl_pending[s] = 1'b0;
            end
         end
         stts_pkg::CMD_STOP: begin
            if (tbl_present[s])
               tbl_pending[s] = 1'b1;
         end
         default: begin
            tbl_timeout[s] = it.timeout_value;
            if (tbl_present[s] && !tbl_pending[s] && it.timeout_value < wake_period)
               changed = set_wake_period(it.timeout_value);
         end
      endcase
      // fired items first, then the status item
      foreach (fired[k]) begin
         rec.kind = stts_pkg::KIND_FIRED;
         rec.fired_slot = 3'(fired[k]);
         rec.next_period = wake_period;
         rec.clock_running = wake_on;
         rec.period_changed = 1'b0;
         rec.last = 1'b0;
         owed_records.push_back(rec);
      end
      rec.kind = stts_pkg::KIND_STATUS;
      rec.fired_slot = 3'd0;
      rec.next_period = wake_period;
      rec.clock_running = wake_on;
      rec.period_changed = changed;
      rec.last = 1'b1;
      owed_records.push_back(rec);
   endtask

   function automatic void match_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // compare every result item with the oldest one owed
   always @(posedge clock) begin
      timer_record_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (owed_records.size() == 0) begin
            $display("%0t ns: result item with none owed, expected nothing, actual slot %0d",
                     $time, rsp_fired_slot);
            mismatches++;
         end else begin
            want = owed_records.pop_front();
            match_field("kind", 32'(want.kind), 32'(rsp_kind));
            match_field("fired_slot", 32'(want.fired_slot), 32'(rsp_fired_slot));
            match_field("next_period", want.next_period, rsp_next_period);
            match_field("clock_running", 32'(want.clock_running), 32'(rsp_clock_running));
            match_field("period_changed", 32'(want.period_changed),
                        32'(rsp_period_changed));
            match_field("last", 32'(want.last), 32'(rsp_last));
         end
      end
   end

   // drive one item after a random gap and hold it until it is taken
   task automatic send_item(input timer_cmd_type it, input bit typed,
                            input logic [31:0] per, input logic run, input logic chg);
      int               gap;
      timer_record_type st;
      gap = calm ? 0 : int'($urandom_range(0, 10));
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_command <= it.command;
      req_slot <= it.slot;
      req_timeout_value <= it.timeout_value;
      req_auto_reload <= it.auto_reload;
      req_now <= it.now;
      start <= 1'b1;
      do
         @(posedge clock);
      while (busy !== 1'b0);
      timer_table_step(it);
      // status read straight off the table for hand-checked rows
      if (typed) begin
         st = owed_records.pop_back();
         st.next_period = per;
         st.clock_running = run;
         st.period_changed = chg;
         owed_records.push_back(st);
      end
   endtask

   // stop sending until every owed item has come, then let the block settle
   task automatic drain_records(input int settle);
      start <= 1'b0;
      while (owed_records.size() != 0)
         @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_callbacks_off(input logic value);
      drain_records(SETTLE_CYCLES);
      csr_wr_data <= value;
      csr_wr_en <= 1'b1;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cb_off = value;
   endtask

   function automatic void plan_step(input stts_pkg::cmd_type c, input int s,
                                     input logic [31:0] tv, input bit ar,
                                     input logic [31:0] nw, input bit typed,
                                     input logic [31:0] per, input bit run, input bit chg);
      plan_row_type r;
      r.csr_row = 1'b0;
      r.csr_value = 1'b0;
      r.item.command = c;
      r.item.slot = 3'(s);
      r.item.timeout_value = tv;
      r.item.auto_reload = ar;
      r.item.now = nw;
      r.typed = typed;
      r.period = per;
      r.running = run;
      r.changed = chg;
      plan.push_back(r);
   endfunction

   function automatic void plan_csr(input logic value);
      plan_row_type r;
      r.csr_row = 1'b1;
      r.csr_value = value;
      r.item.command = stts_pkg::CMD_TICK;
      r.item.slot = 3'd0;
      r.item.timeout_value = 32'd0;
      r.item.auto_reload = 1'b0;
      r.item.now = 32'd0;
      r.typed = 1'b0;
      r.period = 32'd0;
      r.running = 1'b0;
      r.changed = 1'b0;
      plan.push_back(r);
   endfunction

   // mostly well-formed traffic around a slowly advancing time, some noise
   function automatic timer_cmd_type draw_item();
      timer_cmd_type it;
      int            pick;
      pick = $urandom_range(0, 99);
      it.command = stts_pkg::CMD_TICK;
      it.slot = 3'($urandom_range(0, 7));
      it.timeout_value = $urandom_range(0, 60);
      it.auto_reload = 1'($urandom_range(0, 1));
      it.now = sim_ms;
      if (pick < 35) begin
         sim_ms = (pick < 2) ? $urandom : sim_ms + $urandom_range(0, 40);
         it.now = sim_ms;
      end else if (pick < 60) begin
         it.command = stts_pkg::CMD_START;
      end else if (pick < 72) begin
         it.command = stts_pkg::CMD_STOP;
      end else if (pick < 90) begin
         it.command = stts_pkg::CMD_TIMEOUT;
         if (pick >= 88)
            it.timeout_value = $urandom;
         else if (pick >= 86)
            it.timeout_value = stts_pkg::ALL_ONES - $urandom_range(0, 3);
      end else begin
         it.command = stts_pkg::cmd_type'($urandom_range(0, 3));
         it.timeout_value = $urandom;
         it.now = $urandom;
      end
      return it;
   endfunction

   // stimulus
   initial begin
      clear_table();

      // reset state, absent slot, first start, floor of one, wrap of time
      plan_step(stts_pkg::CMD_TICK, 0, 32'd0, 1'b0, 32'd0,
                1'b1, stts_pkg::ALL_ONES, 1'b0, 1'b0);
      plan_step(stts_pkg::CMD_TIMEOUT, 0, 32'd100, 1'b0, 32'd0,
                1'b1, stts_pkg::ALL_ONES, 1'b0, 1'b0);
      plan_step(stts_pkg::CMD_START, 0, 32'd0, 1'b0, 32'd1000, 1'b1, 32'd100, 1'b1, 1'b1);
      plan_step(stts_pkg::CMD_START, 7, 32'd0, 1'b1, 32'd1000, 1'b1, 32'd1, 1'b1, 1'b1);
      plan_step(stts_pkg::CMD_TIMEOUT, 7, stts_pkg::ALL_ONES, 1'b0, 32'd0,
                1'b1, 32'd1, 1'b1, 1'b0);
      plan_step(stts_pkg::CMD_TICK, 0, 32'd0, 1'b0, 32'd1050, 1'b0, 32'd0, 1'b0, 1'b0);
      plan_step(stts_pkg::CMD_TICK, 0, 32'd0, 1'b0, 32'd1100, 1'b0, 32'd0, 1'b0, 1'b0);
      plan_csr(1'b1);
      plan_step(stts_pkg::CMD_TICK, 0, 32'd0, 1'b0, 32'd5000, 1'b0, 32'd0, 1'b0, 1'b0);
      plan_csr(1'b0);
      plan_step(stts_pkg::CMD_STOP, 3, 32'd0, 1'b0, 32'd0, 1'b0, 32'd0, 1'b0, 1'b0);
      plan_step(stts_pkg::CMD_TIMEOUT, 2, 32'd0, 1'b0, 32'd0, 1'b0, 32'd0, 1'b0, 1'b0);
      plan_step(stts_pkg::CMD_START, 2, 32'd0, 1'b0, 32'd5000, 1'b1, 32'd1, 1'b1, 1'b1);
      plan_step(stts_pkg::CMD_STOP, 2, 32'd0, 1'b0, 32'd0, 1'b0, 32'd0, 1'b0, 1'b0);
      plan_step(stts_pkg::CMD_START, 2, 32'd0, 1'b1, 32'd5000, 1'b0, 32'd0, 1'b0, 1'b0);
      plan_step(stts_pkg::CMD_START, 3, 32'd0, 1'b1, 32'hFFFF_FFF0,
                1'b0, 32'd0, 1'b0, 1'b0);
      plan_step(stts_pkg::CMD_TIMEOUT, 3, 32'h20, 1'b0, 32'd0, 1'b0, 32'd0, 1'b0, 1'b0);
      plan_step(stts_pkg::CMD_TICK, 0, 32'd0, 1'b0, stts_pkg::ALL_ONES,
                1'b0, 32'd0, 1'b0, 1'b0);
      plan_step(stts_pkg::CMD_TIMEOUT, 5, stts_pkg::ALL_ONES, 1'b1, 32'd0,
                1'b0, 32'd0, 1'b0, 1'b0);
      plan_step(stts_pkg::CMD_START, 5, 32'd0, 1'b0, 32'd0, 1'b0, 32'd0, 1'b0, 1'b0);
      plan_step(stts_pkg::CMD_STOP, 2, 32'd0, 1'b0, 32'd0, 1'b0, 32'd0, 1'b0, 1'b0);
      plan_step(stts_pkg::CMD_STOP, 3, 32'd0, 1'b0, 32'd0, 1'b0, 32'd0, 1'b0, 1'b0);
      plan_step(stts_pkg::CMD_STOP, 7, 32'd0, 1'b0, 32'd0, 1'b0, 32'd0, 1'b0, 1'b0);
      plan_step(stts_pkg::CMD_STOP, 5, 32'd0, 1'b0, 32'd0, 1'b0, 32'd0, 1'b0, 1'b0);
      plan_step(stts_pkg::CMD_TICK, 0, 32'd0, 1'b0, 32'h10,
                1'b1, stts_pkg::ALL_ONES, 1'b0, 1'b1);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (plan[i]) begin
         if (plan[i].csr_row)
            write_callbacks_off(plan[i].csr_value);
         else
            send_item(plan[i].item, plan[i].typed, plan[i].period, plan[i].running,
                      plan[i].changed);
      end

      // random traffic in three phases of the callback register: enabled, disabled, enabled
      drain_records(0);
      sim_ms = 32'd100;
      for (int n = 0; n < 260; n++) begin
         if (n == 110)
            write_callbacks_off(1'b1);
         if (n == 150)
            write_callbacks_off(1'b0);
         if (n == 60 || $urandom_range(0, 40) == 0)
            drain_records(0);
         if ($urandom_range(0, 19) == 0)
            calm = !calm;
         send_item(draw_item(), 1'b0, 32'd0, 1'b0, 1'b0);
      end

      drain_records(SETTLE_CYCLES);
      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/stts_pkg.sv
sv/stts_ram.sv
sv/stts_eval.sv
sv/software_timer_table_scheduler.sv
tb/software_timer_table_scheduler_test.sv
